// File: hw/rtl/positional_array_list_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional array list engine
// These are shared checks on the clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PALE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");

// The consequent must hold in the cycle after the antecedent.
`define PALE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// File: hw/rtl/pale_pkg.sv
// ----------------------------------------------------------------------------
// Positional array list engine package
// Field widths, default parameters, operation and status codes and states.
// ----------------------------------------------------------------------------
package pale_pkg;

   localparam int CAPACITY_DEF   = 256;
   localparam int WORD_WIDTH_DEF = 32;

   localparam int KIND_W   = 3;
   localparam int SLOT_W   = 9;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 9;

   typedef enum logic [KIND_W-1:0] {
      OP_INSERT = 3'd0,
      OP_APPEND = 3'd1,
      OP_REMOVE = 3'd2,
      OP_FIND   = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_RANGE   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_INS,
      FIN_DEC
   } fin_type;

endpackage

// File: hw/rtl/positional_array_list_engine_unit.sv
// Errors, append and insert at the end walk no entries; other operations walk n entries
// (insert: count - slot, remove: count - slot - 1, find: up to count or a match, read: one).
// The walk reads one entry per cycle on the single read port.
// One beat at a time; a result waits for a free output register, then req_ready rises.
// Reset clears the count, state, pending flag and rsp_valid; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// Positional array list engine
// An ordered list of words in one synchronous memory with insert, append,
// remove, find and read operations, sequenced one memory read per cycle.
// ----------------------------------------------------------------------------
`include "positional_array_list_engine_unit_defines.svh"

module positional_array_list_engine_unit #(
   parameter int CAPACITY   = pale_pkg::CAPACITY_DEF,
   parameter int WORD_WIDTH = pale_pkg::WORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pale_pkg::KIND_W-1:0]   req_kind,
   input  logic [pale_pkg::SLOT_W-1:0]   req_slot,
   input  logic [pale_pkg::DATA_W-1:0]   req_word_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pale_pkg::STATUS_W-1:0] rsp_status,
   output logic [pale_pkg::POS_W-1:0]    rsp_found_slot,
   output logic [pale_pkg::DATA_W-1:0]   rsp_word_out,
   output logic [pale_pkg::COUNT_W-1:0]  rsp_count,
   output logic                          rsp_empty_res
);

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int CW = (FW > pale_pkg::SLOT_W) ? FW : pale_pkg::SLOT_W;

   pale_pkg::state_type  state_ff, state_in;
   pale_pkg::op_type     mode_ff, mode_in;
   pale_pkg::fin_type    fin_ff, fin_in;
   pale_pkg::status_type res_status_ff, res_status_in;
   logic [pale_pkg::POS_W-1:0]  res_found_ff, res_found_in;
   logic [pale_pkg::DATA_W-1:0] res_word_ff, res_word_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [WORD_WIDTH-1:0] key_ff, key_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [FW-1:0]         left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [FW-1:0]         fill_next;

   logic                  rsp_valid_ff, rsp_valid_in;
   pale_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [pale_pkg::POS_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [pale_pkg::DATA_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [pale_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic [WORD_WIDTH-1:0] entries_ff [CAPACITY];
   logic [WORD_WIDTH-1:0] mem_rdata_ff;
   logic                  mem_re, mem_we;
   logic [AW-1:0]         mem_raddr, mem_waddr;
   logic [WORD_WIDTH-1:0] mem_wdata;

   logic [CW-1:0] slot_ext, fill_ext;
   logic          fill_full, hit, out_free;

   assign slot_ext  = CW'(req_slot);
   assign fill_ext  = CW'(fill_ff);
   assign fill_full = (fill_ff == FW'(CAPACITY));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (fin_ff)
         pale_pkg::FIN_INS: fill_next = fill_ff + FW'(1);
         pale_pkg::FIN_DEC: fill_next = fill_ff - FW'(1);
         default:           fill_next = fill_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      fin_in        = fin_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_word_in   = res_word_ff;
      addr_in       = addr_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      req_ready     = (state_ff == pale_pkg::ST_IDLE);
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_raddr     = ptr_ff;
      mem_waddr     = addr_ff;
      mem_wdata     = key_ff;
      hit           = 1'b0;

      case (state_ff)
         pale_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in       = pale_pkg::op_type'(req_kind);
               key_in        = WORD_WIDTH'(req_word_in);
               addr_in       = AW'(slot_ext);
               res_status_in = pale_pkg::STAT_OK;
               res_found_in  = '0;
               res_word_in   = '0;
               fin_in        = pale_pkg::FIN_NONE;
               state_in      = pale_pkg::ST_FINAL;
               case (req_kind)
                  pale_pkg::OP_INSERT: begin
                     if (slot_ext > fill_ext) begin
                        res_status_in = pale_pkg::STAT_RANGE;
                     end else if (fill_full) begin
                        res_status_in = pale_pkg::STAT_FULL;
                     end else begin
                        fin_in = pale_pkg::FIN_INS;
                        if (slot_ext != fill_ext) begin
                           ptr_in   = AW'(fill_ff - FW'(1));
                           left_in  = FW'(fill_ext - slot_ext);
                           state_in = pale_pkg::ST_RUN;
                        end
                     end
                  end
                  pale_pkg::OP_APPEND: begin
                     if (fill_full) begin
                        res_status_in = pale_pkg::STAT_FULL;
                     end else begin
                        addr_in = AW'(fill_ff);
                        fin_in  = pale_pkg::FIN_INS;
                     end
                  end
                  pale_pkg::OP_REMOVE: begin
                     if (slot_ext >= fill_ext) begin
                        res_status_in = pale_pkg::STAT_RANGE;
                     end else begin
                        fin_in = pale_pkg::FIN_DEC;
                        if (slot_ext + CW'(1) != fill_ext) begin
                           ptr_in   = AW'(slot_ext + CW'(1));
                           left_in  = FW'(fill_ext - slot_ext - CW'(1));
                           state_in = pale_pkg::ST_RUN;
                        end
                     end
                  end
                  pale_pkg::OP_FIND: begin
                     res_status_in = pale_pkg::STAT_MISSING;
                     if (fill_ff != '0) begin
                        ptr_in   = '0;
                        left_in  = fill_ff;
                        state_in = pale_pkg::ST_RUN;
                     end
                  end
                  pale_pkg::OP_READ: begin
                     if (slot_ext >= fill_ext) begin
                        res_status_in = pale_pkg::STAT_RANGE;
                     end else begin
                        ptr_in   = AW'(slot_ext);
                        left_in  = FW'(1);
                        state_in = pale_pkg::ST_RUN;
                     end
                  end
                  default: begin
                     res_status_in = pale_pkg::STAT_RANGE;
                  end
               endcase
            end
         end
         pale_pkg::ST_RUN: begin
            if (pend_ff) begin
               case (mode_ff)
                  pale_pkg::OP_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pend_addr_ff + AW'(1);
                     mem_wdata = mem_rdata_ff;
                  end
                  pale_pkg::OP_REMOVE: begin
                     mem_we    = 1'b1;
                     mem_waddr = pend_addr_ff - AW'(1);
                     mem_wdata = mem_rdata_ff;
                  end
                  pale_pkg::OP_FIND: begin
                     if (mem_rdata_ff == key_ff) begin
                        hit           = 1'b1;
                        res_status_in = pale_pkg::STAT_OK;
                        res_found_in  = pale_pkg::POS_W'(pend_addr_ff);
                     end
                  end
                  pale_pkg::OP_READ: begin
                     res_word_in = pale_pkg::DATA_W'(mem_rdata_ff);
                  end
                  default: begin
                  end
               endcase
            end
            if (!hit && left_ff != '0) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               left_in      = left_ff - FW'(1);
               if (mode_ff == pale_pkg::OP_INSERT) begin
                  ptr_in = ptr_ff - AW'(1);
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
            if (hit || left_ff == '0) begin
               state_in = pale_pkg::ST_FINAL;
            end
         end
         pale_pkg::ST_FINAL: begin
            if (out_free) begin
               if (fin_ff == pale_pkg::FIN_INS) begin
                  mem_we = 1'b1;
               end
               fill_in       = fill_next;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_word_in   = res_word_ff;
               rsp_count_in  = pale_pkg::COUNT_W'(fill_next);
               rsp_empty_in  = (fill_next == '0);
               state_in      = pale_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pale_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pale_pkg::ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      fin_ff        <= fin_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_word_ff   <= res_word_in;
      addr_ff       <= addr_in;
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= entries_ff[mem_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_slot = rsp_found_ff;
   assign rsp_word_out   = rsp_word_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_empty_res  = rsp_empty_ff;

   `PALE_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != pale_pkg::ST_IDLE)
   `PALE_ASSERT_SAME(a_no_write_when_idle, mem_we, state_ff != pale_pkg::ST_IDLE)
   `PALE_ASSERT_SAME(a_full_means_capacity, rsp_valid && rsp_status == pale_pkg::STAT_FULL, fill_full)

endmodule
